@@ hw/rtl/bic_pkg.sv @@
// Package for the box IoU cost block: fixed widths and queue sizing.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package bic_pkg;

  // box width and height are always 14-bit unsigned
  localparam int EXT_W = 14;
  // one box area, and the sum of two areas
  localparam int AREA_W = 2 * EXT_W;
  localparam int UNI_W = AREA_W + 1;

  // queue between geometry front end and divider back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

endpackage

@@ hw/rtl/bic_ifs.sv @@
// Valid/ready channel interfaces for box pairs in and cost items out.
// Depends on bic_pkg for the extent width.
`timescale 1ns / 1ps

interface bic_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                                valid;
  logic                                ready;
  logic signed [COORD_WIDTH-1:0]       track_left;
  logic signed [COORD_WIDTH-1:0]       track_top;
  logic        [bic_pkg::EXT_W-1:0]    track_width;
  logic        [bic_pkg::EXT_W-1:0]    track_height;
  logic signed [COORD_WIDTH-1:0]       det_left;
  logic signed [COORD_WIDTH-1:0]       det_top;
  logic        [bic_pkg::EXT_W-1:0]    det_width;
  logic        [bic_pkg::EXT_W-1:0]    det_height;
  logic                                track_stale;

  modport source (
    output valid, track_left, track_top, track_width, track_height,
           det_left, det_top, det_width, det_height, track_stale,
    input  ready
  );
  modport sink (
    input  valid, track_left, track_top, track_width, track_height,
           det_left, det_top, det_width, det_height, track_stale,
    output ready
  );
endinterface

interface bic_out_if #(
  parameter int COST_FRAC_BITS = 16
);
  logic                      valid;
  logic                      ready;
  logic [COST_FRAC_BITS:0]   cost;
  logic                      cost_infinite;

  modport source (output valid, cost, cost_infinite, input ready);
  modport sink (input valid, cost, cost_infinite, output ready);
endinterface

@@ hw/rtl/bic_front.sv @@
// Geometry front end: intersection, areas, union and divider numerator.
// Five-stage pipeline with one shared stall enable. Depends on bic_pkg, bic_ifs.
`timescale 1ns / 1ps

module bic_front #(
  parameter int COORD_WIDTH = 16,
  parameter int COST_FRAC_BITS = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  bic_in_if.sink                                        in_i,
  output logic                                          valid_o,
  input  logic                                          ready_i,
  output logic [bic_pkg::AREA_W+COST_FRAC_BITS:0]       num_o,
  output logic [bic_pkg::UNI_W-1:0]                     uni_o,
  output logic                                          special_o,
  output logic                                          stale_o
);

  localparam int SUM_W = ((COORD_WIDTH > bic_pkg::EXT_W) ? COORD_WIDTH : bic_pkg::EXT_W) + 2;
  localparam int NUM_W = bic_pkg::AREA_W + COST_FRAC_BITS + 1;

  logic [4:0] v_q;
  logic       en;

  logic signed [SUM_W-1:0] tl, tt, dl, dt, tr, tb, dr, db;

  // stage 1: corners of the intersection
  logic signed [SUM_W-1:0]      s1_x0_q, s1_y0_q, s1_x1_q, s1_y1_q;
  logic [bic_pkg::EXT_W-1:0]    s1_tw_q, s1_th_q, s1_dw_q, s1_dh_q;
  logic                         s1_st_q;
  // stage 2: clamped extents and box areas
  logic signed [SUM_W:0]        dx, dy;
  logic [bic_pkg::EXT_W-1:0]    s2_iw_q, s2_ih_q;
  logic [bic_pkg::AREA_W-1:0]   s2_at_q, s2_ad_q;
  logic                         s2_st_q;
  // stage 3: intersection area, area sum
  logic [bic_pkg::AREA_W-1:0]   s3_in_q;
  logic [bic_pkg::UNI_W-1:0]    s3_as_q;
  logic                         s3_st_q;
  // stage 4: union
  logic [bic_pkg::AREA_W-1:0]   s4_in_q;
  logic [bic_pkg::UNI_W-1:0]    s4_un_q;
  logic                         s4_st_q;
  // stage 5: numerator and special flag
  logic [NUM_W-1:0]             s5_num_q;
  logic [bic_pkg::UNI_W-1:0]    s5_un_q;
  logic                         s5_sp_q, s5_st_q;

  assign en = !v_q[4] || ready_i;
  assign in_i.ready = en;

  assign tl = $signed({{(SUM_W-COORD_WIDTH){in_i.track_left[COORD_WIDTH-1]}}, in_i.track_left});
  assign tt = $signed({{(SUM_W-COORD_WIDTH){in_i.track_top[COORD_WIDTH-1]}}, in_i.track_top});
  assign dl = $signed({{(SUM_W-COORD_WIDTH){in_i.det_left[COORD_WIDTH-1]}}, in_i.det_left});
  assign dt = $signed({{(SUM_W-COORD_WIDTH){in_i.det_top[COORD_WIDTH-1]}}, in_i.det_top});
  assign tr = tl + $signed({{(SUM_W-bic_pkg::EXT_W){1'b0}}, in_i.track_width});
  assign tb = tt + $signed({{(SUM_W-bic_pkg::EXT_W){1'b0}}, in_i.track_height});
  assign dr = dl + $signed({{(SUM_W-bic_pkg::EXT_W){1'b0}}, in_i.det_width});
  assign db = dt + $signed({{(SUM_W-bic_pkg::EXT_W){1'b0}}, in_i.det_height});

  assign dx = $signed({s1_x1_q[SUM_W-1], s1_x1_q}) - $signed({s1_x0_q[SUM_W-1], s1_x0_q});
  assign dy = $signed({s1_y1_q[SUM_W-1], s1_y1_q}) - $signed({s1_y0_q[SUM_W-1], s1_y0_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[3:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x0_q <= (tl > dl) ? tl : dl;
      s1_y0_q <= (tt > dt) ? tt : dt;
      s1_x1_q <= (tr < dr) ? tr : dr;
      s1_y1_q <= (tb < db) ? tb : db;
      s1_tw_q <= in_i.track_width;
      s1_th_q <= in_i.track_height;
      s1_dw_q <= in_i.det_width;
      s1_dh_q <= in_i.det_height;
      s1_st_q <= in_i.track_stale;

      // a nonnegative extent never exceeds the narrower box, so it fits
      s2_iw_q <= dx[SUM_W] ? '0 : dx[bic_pkg::EXT_W-1:0];
      s2_ih_q <= dy[SUM_W] ? '0 : dy[bic_pkg::EXT_W-1:0];
      s2_at_q <= {{bic_pkg::EXT_W{1'b0}}, s1_tw_q} * {{bic_pkg::EXT_W{1'b0}}, s1_th_q};
      s2_ad_q <= {{bic_pkg::EXT_W{1'b0}}, s1_dw_q} * {{bic_pkg::EXT_W{1'b0}}, s1_dh_q};
      s2_st_q <= s1_st_q;

      s3_in_q <= {{bic_pkg::EXT_W{1'b0}}, s2_iw_q} * {{bic_pkg::EXT_W{1'b0}}, s2_ih_q};
      s3_as_q <= {1'b0, s2_at_q} + {1'b0, s2_ad_q};
      s3_st_q <= s2_st_q;

      s4_in_q <= s3_in_q;
      s4_un_q <= s3_as_q - {1'b0, s3_in_q};
      s4_st_q <= s3_st_q;

      s5_num_q <= {1'b0, s4_in_q, {COST_FRAC_BITS{1'b0}}}
                + {{(NUM_W-bic_pkg::AREA_W){1'b0}}, s4_un_q[bic_pkg::UNI_W-1:1]};
      s5_un_q  <= s4_un_q;
      s5_sp_q  <= s4_st_q || (s4_un_q == '0);
      s5_st_q  <= s4_st_q;
    end
  end

  assign valid_o   = v_q[4];
  assign num_o     = s5_num_q;
  assign uni_o     = s5_un_q;
  assign special_o = s5_sp_q;
  assign stale_o   = s5_st_q;

endmodule

@@ hw/rtl/bic_fifo.sv @@
// Small valid/ready queue that decouples the front end from the divider.
// Depends on bic_pkg for depth and pointer width.
`timescale 1ns / 1ps

module bic_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0]            mem_q [bic_pkg::QUEUE_DEPTH];
  logic [bic_pkg::QPTR_W-1:0]  wptr_q, rptr_q;
  logic [bic_pkg::QPTR_W:0]    cnt_q;
  logic                        push, pop;

  assign ready_o = (cnt_q != (bic_pkg::QPTR_W+1)'(bic_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (bic_pkg::QPTR_W+1)'(bic_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");
  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a push");
  a_cnt_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue count missed a pop");
`endif

endmodule

@@ hw/rtl/bic_back.sv @@
// Back end: pipelined restoring divider, one quotient bit per stage, then
// the cost output register. Depends on bic_pkg and bic_ifs.
`timescale 1ns / 1ps

module bic_back #(
  parameter int COST_FRAC_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic [bic_pkg::AREA_W+COST_FRAC_BITS:0]  num_i,
  input  logic [bic_pkg::UNI_W-1:0]                uni_i,
  input  logic                                     special_i,
  input  logic                                     stale_i,
  bic_out_if.source                                out_o
);

  localparam int QW = COST_FRAC_BITS + 1;
  localparam int NSTG = QW;
  localparam int NUM_W = bic_pkg::AREA_W + COST_FRAC_BITS + 1;
  localparam logic [QW-1:0] ONE = {1'b1, {COST_FRAC_BITS{1'b0}}};

  logic en;

  logic [NSTG-1:0]             dv_q;
  logic [bic_pkg::UNI_W-1:0]   r_q [NSTG];
  logic [bic_pkg::UNI_W-1:0]   u_q [NSTG];
  logic [QW-1:0]               b_q [NSTG];
  logic [QW-1:0]               q_q [NSTG];
  logic                        sp_q [NSTG];
  logic                        st_q [NSTG];

  logic                        v_in [NSTG];
  logic [bic_pkg::UNI_W-1:0]   r_in [NSTG];
  logic [bic_pkg::UNI_W-1:0]   u_in [NSTG];
  logic [QW-1:0]               b_in [NSTG];
  logic [QW-1:0]               q_in [NSTG];
  logic                        sp_in [NSTG];
  logic                        st_in [NSTG];
  logic [bic_pkg::UNI_W:0]     t [NSTG];
  logic [bic_pkg::UNI_W:0]     df [NSTG];
  logic                        ge [NSTG];
  logic [bic_pkg::UNI_W-1:0]   r_nxt [NSTG];

  logic            ov_q;
  logic [QW-1:0]   cost_q;
  logic            inf_q;

  assign en = !ov_q || out_o.ready;
  assign ready_o = en;

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    if (k == 0) begin : g_first
      // top numerator bits start below the divisor since num < uni * 2^QW
      assign v_in[k]  = valid_i;
      assign r_in[k]  = {1'b0, num_i[NUM_W-1:QW]};
      assign u_in[k]  = uni_i;
      assign b_in[k]  = num_i[QW-1:0];
      assign q_in[k]  = '0;
      assign sp_in[k] = special_i;
      assign st_in[k] = stale_i;
    end else begin : g_next
      assign v_in[k]  = dv_q[k-1];
      assign r_in[k]  = r_q[k-1];
      assign u_in[k]  = u_q[k-1];
      assign b_in[k]  = b_q[k-1];
      assign q_in[k]  = q_q[k-1];
      assign sp_in[k] = sp_q[k-1];
      assign st_in[k] = st_q[k-1];
    end
    assign t[k]     = {r_in[k], b_in[k][QW-1]};
    assign df[k]    = t[k] - {1'b0, u_in[k]};
    assign ge[k]    = (t[k] >= {1'b0, u_in[k]});
    assign r_nxt[k] = ge[k] ? df[k][bic_pkg::UNI_W-1:0] : t[k][bic_pkg::UNI_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NSTG; k++) begin
        dv_q[k] <= v_in[k];
      end
      ov_q <= dv_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NSTG; k++) begin
        r_q[k]  <= r_nxt[k];
        u_q[k]  <= u_in[k];
        b_q[k]  <= {b_in[k][QW-2:0], 1'b0};
        q_q[k]  <= {q_in[k][QW-2:0], ge[k]};
        sp_q[k] <= sp_in[k];
        st_q[k] <= st_in[k];
      end
      cost_q <= sp_q[NSTG-1] ? ONE : (ONE - q_q[NSTG-1]);
      inf_q  <= st_q[NSTG-1];
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.cost          = cost_q;
  assign out_o.cost_infinite = inf_q;

`ifndef SYNTH
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[NSTG-1] && !sp_q[NSTG-1] |-> q_q[NSTG-1] <= ONE)
    else $error("IoU quotient above one");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[NSTG-1] && !sp_q[NSTG-1] |-> r_q[NSTG-1] < u_q[NSTG-1])
    else $error("divider remainder not below union");
  a_inf_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && inf_q |-> cost_q == ONE)
    else $error("stale item without full cost");
`endif

endmodule

@@ hw/rtl/box_iou_cost.sv @@
// box_iou_cost: 1 - IoU of a track box and a detection box, unsigned Q1.F.
// Path: front-end stages, then the queue, the divider stages and the cost register.
// Throughput: one item per cycle while out_o is ready; the divider retires one quotient bit per stage.
// The 4-entry queue lets the geometry front end run while the output stalls.
// Reset clears all valid bits and queue pointers at once; no clearing pass.
// Depends on bic_pkg, bic_ifs, bic_front, bic_fifo, bic_back.
`timescale 1ns / 1ps

module box_iou_cost #(
  parameter int COORD_WIDTH = 16,
  parameter int COST_FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bic_in_if.sink     in_i,
  bic_out_if.source  out_o
);

  localparam int NUM_W = bic_pkg::AREA_W + COST_FRAC_BITS + 1;
  localparam int QD_W = NUM_W + bic_pkg::UNI_W + 2;

  logic                       f_valid, f_ready;
  logic [NUM_W-1:0]           f_num;
  logic [bic_pkg::UNI_W-1:0]  f_uni;
  logic                       f_special, f_stale;

  logic                       b_valid, b_ready;
  logic [QD_W-1:0]            b_data;

  bic_front #(
    .COORD_WIDTH    (COORD_WIDTH),
    .COST_FRAC_BITS (COST_FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .valid_o   (f_valid),
    .ready_i   (f_ready),
    .num_o     (f_num),
    .uni_o     (f_uni),
    .special_o (f_special),
    .stale_o   (f_stale)
  );

  bic_fifo #(
    .WIDTH (QD_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .data_i  ({f_num, f_uni, f_special, f_stale}),
    .valid_o (b_valid),
    .ready_i (b_ready),
    .data_o  (b_data)
  );

  bic_back #(
    .COST_FRAC_BITS (COST_FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (b_valid),
    .ready_o   (b_ready),
    .num_i     (b_data[QD_W-1 -: NUM_W]),
    .uni_i     (b_data[bic_pkg::UNI_W+1:2]),
    .special_i (b_data[1]),
    .stale_i   (b_data[0]),
    .out_o     (out_o)
  );

endmodule
